>>> design/edtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-deadline timer dispatcher package
// Shared widths, operation codes, register map and time helpers.
// ----------------------------------------------------------------------------
package edtd_pkg;

    // Table size and field widths.
    localparam int NUM_TIMERS = 16;
    localparam int TIME_W     = 40;
    localparam int ID_W       = 4;
    localparam int MODE_W     = 3;
    localparam int ALIVE_W    = 5;
    localparam int SLACK_W    = 10;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    // Configuration port shape: one 32-bit register at byte address 0.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_DUE_SLACK = REG_IDX_W'(0);
    localparam logic [SLACK_W-1:0]   SLACK_RESET   = SLACK_W'(10);

    // Operation codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESCHED  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ADJUST   = 3'd6;

    typedef logic [TIME_W-1:0] time_t;

    localparam time_t TIME_MAX = '1;

    // Absolute distance between two unsigned times.
    function automatic time_t abs_diff(input time_t a, input time_t b);
        time_t d;
        if (a >= b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

    // Unsigned time sum, saturated at the largest time.
    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

>>> design/edtd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher configuration registers
// APB-style register file holding the early-fire slack.
// ----------------------------------------------------------------------------
module edtd_cfg import edtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [SLACK_W-1:0] due_slack
);

    logic [SLACK_W-1:0]   due_slack_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Word index of the addressed register.
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write on the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_slack_reg <= SLACK_RESET;
        end
        else if (wr_en && (reg_idx == REG_DUE_SLACK))
        begin
            due_slack_reg <= pwdata[SLACK_W-1:0];
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb
    begin
        if (reg_idx == REG_DUE_SLACK)
        begin
            prdata = PDATA_W'(due_slack_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign due_slack = due_slack_reg;

endmodule

>>> design/earliest_deadline_timer_dispatcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-deadline timer dispatcher
// Timer table with tick dispatch, per-timer commands and clock adjustment.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the result transaction, which appears for one cycle with done high and
// cannot be held off. Every command gives exactly one result. The table of
// next-due times sits in a single-port-read memory that one sequencer walks
// an entry at a time: a tick compares every entry before it dispatches, an
// adjust-all weighs the shift for each scheduled entry, and every other
// command acts on its one entry. The user must write the slack register
// through the APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module earliest_deadline_timer_dispatcher_top import edtd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Command transaction
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        mode,
    input  logic [ID_W-1:0]          timer_id,
    input  logic [TIME_W-1:0]        now,
    input  logic [TIME_W-1:0]        interval_value,
    input  logic [TIME_W-1:0]        due_time,
    input  logic signed [TIME_W-1:0] adjustment,
    // Result transaction
    output logic                     done,
    output logic                     fire_valid,
    output logic [ID_W-1:0]          fire_id,
    output logic [ALIVE_W-1:0]       alive_count,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_ADJ2 = 3'd3;
    localparam logic [2:0] S_ADJ3 = 3'd4;
    localparam logic [2:0] S_FIRE = 3'd5;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);
    localparam int               SUM_W    = TIME_W + 2;

    logic [SLACK_W-1:0] due_slack;

    // Sequencer and flag state.
    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [NUM_TIMERS-1:0] started_reg, started_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] sched_reg, sched_next;
    logic [CNT_W-1:0]      started_total_reg, started_total_next;
    logic [NUM_TIMERS-1:0] due_valid_reg;
    logic [NUM_TIMERS-1:0] per_valid_reg;

    // Result registers.
    logic               done_reg, done_next;
    logic               fire_valid_reg, fire_valid_next;
    logic [ID_W-1:0]    fire_id_reg, fire_id_next;
    logic [ALIVE_W-1:0] alive_reg, alive_next;

    // Search and adjustment working registers.
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    time_t            best_due_reg, best_due_next;
    time_t            cand_reg, cand_next;
    time_t            dold_reg, dold_next;
    time_t            dcand_reg, dcand_next;

    // Latched command.
    logic [MODE_W-1:0]        mode_reg;
    logic [ID_W-1:0]          id_reg;
    time_t                    now_reg;
    time_t                    ivl_reg;
    time_t                    dt_reg;
    logic signed [TIME_W-1:0] adj_reg;

    // Timer memories.
    time_t            due_mem [NUM_TIMERS];
    time_t            per_mem [NUM_TIMERS];
    time_t            due_rd_reg;
    time_t            per_rd_reg;
    logic             due_rdv_reg;
    logic             per_rdv_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             due_we;
    logic [IDX_W-1:0] due_waddr;
    time_t            due_wdata;
    logic             per_we;

    logic             accept;
    logic             finish;
    logic             fire_hit;
    logic             addr_ok;
    logic [IDX_W-1:0] id_idx;
    logic             scan_mode;
    time_t            due_old;
    time_t            per_val;
    time_t            resched_due;
    logic [SUM_W-1:0] adj_sum;
    time_t            adj_sat;
    logic [TIME_W:0]  fire_limit;

    // Saturate the started count into the result field.
    function automatic logic [ALIVE_W-1:0] sat_alive(input logic [CNT_W-1:0] c);
        logic [ALIVE_W-1:0] r;
        if (32'(c) > 32'((1 << ALIVE_W) - 1))
        begin
            r = '1;
        end
        else
        begin
            r = ALIVE_W'(c);
        end
        return r;
    endfunction

    edtd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .due_slack (due_slack)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Command decode and read address: scans walk the table, others use the id.
    assign id_idx    = IDX_W'(id_reg);
    assign addr_ok   = (32'(id_reg) < 32'(NUM_TIMERS));
    assign scan_mode = (mode_reg == MODE_TICK) || (mode_reg == MODE_ADJUST);
    assign rd_addr   = scan_mode ? idx_reg : id_idx;

    // Entries never written since reset read as zero.
    assign due_old = due_rdv_reg ? due_rd_reg : '0;
    assign per_val = per_rdv_reg ? per_rd_reg : '0;

    // Shared time arithmetic.
    assign resched_due = sat_add(now_reg, per_val);
    assign adj_sum     = {2'b00, due_old} + {{2{adj_reg[TIME_W-1]}}, adj_reg};
    assign adj_sat     = adj_sum[SUM_W-1] ? '0 :
                         (adj_sum[TIME_W] ? TIME_MAX : adj_sum[TIME_W-1:0]);
    assign fire_limit  = {1'b0, now_reg} + (TIME_W + 1)'(due_slack);
    assign fire_hit    = best_found_reg && ({1'b0, best_due_reg} <= fire_limit);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        started_next       = started_reg;
        running_next       = running_reg;
        sched_next         = sched_reg;
        started_total_next = started_total_reg;
        best_found_next    = best_found_reg;
        best_idx_next      = best_idx_reg;
        best_due_next      = best_due_reg;
        cand_next          = cand_reg;
        dold_next          = dold_reg;
        dcand_next         = dcand_reg;
        done_next          = 1'b0;
        fire_valid_next    = fire_valid_reg;
        fire_id_next       = fire_id_reg;
        alive_next         = alive_reg;
        due_we             = 1'b0;
        due_waddr          = id_idx;
        due_wdata          = resched_due;
        per_we             = 1'b0;
        finish             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (mode_reg)
                    MODE_TICK:
                    begin
                        // Strict compare keeps the lowest index on equal times.
                        if (sched_reg[idx_reg] &&
                            (!best_found_reg || (due_old < best_due_reg)))
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = idx_reg;
                            best_due_next   = due_old;
                        end
                        if (idx_reg == IDX_LAST)
                        begin
                            state_next = S_FIRE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end

                    MODE_ADJUST:
                    begin
                        if (sched_reg[idx_reg])
                        begin
                            cand_next  = adj_sat;
                            dold_next  = abs_diff(now_reg, due_old);
                            state_next = S_ADJ2;
                        end
                        else if (idx_reg == IDX_LAST)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end

                    MODE_START:
                    begin
                        if (addr_ok)
                        begin
                            if (!started_reg[id_idx])
                            begin
                                started_total_next = started_total_reg + 1'b1;
                            end
                            started_next[id_idx] = 1'b1;
                            if (per_val != '0)
                            begin
                                due_we = 1'b1;
                                if (!running_reg[id_idx])
                                begin
                                    sched_next[id_idx] = 1'b1;
                                end
                            end
                        end
                        finish = 1'b1;
                    end

                    MODE_STOP:
                    begin
                        if (addr_ok)
                        begin
                            if (started_reg[id_idx] && (started_total_reg != '0))
                            begin
                                started_total_next = started_total_reg - 1'b1;
                            end
                            started_next[id_idx] = 1'b0;
                            sched_next[id_idx]   = 1'b0;
                        end
                        finish = 1'b1;
                    end

                    MODE_INTERVAL:
                    begin
                        per_we = addr_ok;
                        finish = 1'b1;
                    end

                    MODE_RESCHED:
                    begin
                        if (addr_ok)
                        begin
                            due_we    = 1'b1;
                            due_wdata = dt_reg;
                            if (started_reg[id_idx] && !running_reg[id_idx])
                            begin
                                sched_next[id_idx] = 1'b1;
                            end
                        end
                        finish = 1'b1;
                    end

                    MODE_COMPLETE:
                    begin
                        if (addr_ok)
                        begin
                            running_next[id_idx] = 1'b0;
                            if (per_val != '0)
                            begin
                                due_we = 1'b1;
                                if (started_reg[id_idx])
                                begin
                                    sched_next[id_idx] = 1'b1;
                                end
                            end
                        end
                        finish = 1'b1;
                    end

                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            S_ADJ2:
            begin
                dcand_next = abs_diff(now_reg, cand_reg);
                state_next = S_ADJ3;
            end

            S_ADJ3:
            begin
                // Take the shifted time only when it lands strictly closer to now.
                if (dcand_reg < dold_reg)
                begin
                    due_we    = 1'b1;
                    due_waddr = idx_reg;
                    due_wdata = cand_reg;
                end
                if (idx_reg == IDX_LAST)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end

            S_FIRE:
            begin
                if (fire_hit)
                begin
                    sched_next[best_idx_reg]   = 1'b0;
                    running_next[best_idx_reg] = 1'b1;
                end
                finish = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result transaction for the finished command.
        if (finish)
        begin
            state_next      = S_IDLE;
            done_next       = 1'b1;
            fire_valid_next = (state_reg == S_FIRE) && fire_hit;
            fire_id_next    = ((state_reg == S_FIRE) && fire_hit) ?
                              ID_W'(best_idx_reg) : '0;
            alive_next      = sat_alive(started_total_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            started_reg       <= '0;
            running_reg       <= '0;
            sched_reg         <= '0;
            started_total_reg <= '0;
            due_valid_reg     <= '0;
            per_valid_reg     <= '0;
            done_reg          <= 1'b0;
            fire_valid_reg    <= 1'b0;
            fire_id_reg       <= '0;
            alive_reg         <= '0;
            best_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            started_reg       <= started_next;
            running_reg       <= running_next;
            sched_reg         <= sched_next;
            started_total_reg <= started_total_next;
            done_reg          <= done_next;
            fire_valid_reg    <= fire_valid_next;
            fire_id_reg       <= fire_id_next;
            alive_reg         <= alive_next;
            best_found_reg    <= best_found_next;
            if (due_we)
            begin
                due_valid_reg[due_waddr] <= 1'b1;
            end
            if (per_we)
            begin
                per_valid_reg[id_idx] <= 1'b1;
            end
        end
    end

    // Working registers and the latched command.
    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_due_reg <= best_due_next;
        cand_reg     <= cand_next;
        dold_reg     <= dold_next;
        dcand_reg    <= dcand_next;
        if (accept)
        begin
            mode_reg <= mode;
            id_reg   <= timer_id;
            now_reg  <= now;
            ivl_reg  <= interval_value;
            dt_reg   <= due_time;
            adj_reg  <= adjustment;
        end
    end

    // Due-time and interval memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_waddr] <= due_wdata;
        end
        if (per_we)
        begin
            per_mem[id_idx] <= ivl_reg;
        end
        due_rd_reg  <= due_mem[rd_addr];
        per_rd_reg  <= per_mem[rd_addr];
        due_rdv_reg <= due_valid_reg[rd_addr];
        per_rdv_reg <= per_valid_reg[rd_addr];
    end

    assign done        = done_reg;
    assign fire_valid  = fire_valid_reg;
    assign fire_id     = fire_id_reg;
    assign alive_count = alive_reg;

    // The result transaction comes in the cycle the block turns ready again.
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result transaction");

    // An accepted command always occupies the sequencer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not start the sequencer");

    // A dispatched timer is running and no longer scheduled.
    a_fired_running: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fire_valid) |->
            (running_reg[IDX_W'(fire_id)] && !sched_reg[IDX_W'(fire_id)]))
        else $error("dispatched timer not marked running");

    // The started count tracks the started flags.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(started_total_reg) == 32'($countones(started_reg)))
        else $error("started count out of step with started flags");

endmodule
